@@ hw/rtl/wfws_pkg.sv @@
// Shared types and constants for the waypoint follower wheel speed unit.
package wfws_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_POSE   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] REG_MAX_SPEED = 3'd0;
    localparam logic [2:0] REG_TOL       = 3'd4;

    localparam int ANG_W = 27;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 27'sd102944;
    localparam logic signed [17:0] PI_Q13     = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [17:0] ROT_LIMIT  = 18'sd2048;

    localparam logic [13:0] MAX_SPEED_RST = 14'd2048;
    localparam logic [15:0] TOL_RST       = 16'd1311;

    localparam int WP_W = 64;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] v;
    } wp_entry_t;

    // arctangent table, Q16 radians
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0:  atan_q16 = 27'sd51472;
            5'd1:  atan_q16 = 27'sd30386;
            5'd2:  atan_q16 = 27'sd16055;
            5'd3:  atan_q16 = 27'sd8150;
            5'd4:  atan_q16 = 27'sd4091;
            5'd5:  atan_q16 = 27'sd2047;
            5'd6:  atan_q16 = 27'sd1024;
            5'd7:  atan_q16 = 27'sd512;
            5'd8:  atan_q16 = 27'sd256;
            5'd9:  atan_q16 = 27'sd128;
            5'd10: atan_q16 = 27'sd64;
            5'd11: atan_q16 = 27'sd32;
            5'd12: atan_q16 = 27'sd16;
            5'd13: atan_q16 = 27'sd8;
            5'd14: atan_q16 = 27'sd4;
            5'd15: atan_q16 = 27'sd2;
            5'd16: atan_q16 = 27'sd1;
            default: atan_q16 = '0;
        endcase
    endfunction

endpackage

@@ hw/rtl/wfws_ram.sv @@
// Generic single-port RAM with registered read.
module wfws_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

@@ hw/rtl/wfws_cordic.sv @@
// Iterative CORDIC vectoring unit: one shift-add step per cycle.
module wfws_cordic
    import wfws_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [24:0] dx,
    input  logic signed [24:0] dy,
    output logic               done,
    output logic signed [17:0] angle
);
    localparam int CW = 28;
    localparam int SW = $clog2(CORDIC_STEPS + 1);

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic [SW-1:0] step_reg, step_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic zero_reg, zero_next;
    logic signed [CW-1:0] xs, ys, dxe, dye;
    logic signed [ANG_W-1:0] zr;

    assign dxe = CW'(dx);
    assign dye = CW'(dy);
    assign xs  = x_reg >>> step_reg;
    assign ys  = y_reg >>> step_reg;

    always_comb begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        step_next = step_reg; busy_next = busy_reg; done_next = 1'b0;
        zero_next = zero_reg;
        if (start) begin
            step_next = '0;
            busy_next = 1'b1;
            // target exactly at the pose: bearing is 0
            zero_next = (dx == 25'sd0) && (dy == 25'sd0);
            x_next = dxe; y_next = dye; z_next = '0;
            if (dx < 0) begin
                if (dy >= 0) begin
                    x_next = dye; y_next = -dxe; z_next = HALF_PI_Q16;
                end else begin
                    x_next = -dye; y_next = dxe; z_next = -HALF_PI_Q16;
                end
            end
        end else if (busy_reg) begin
            if (y_reg >= 0) begin
                x_next = x_reg + ys; y_next = y_reg - xs;
                z_next = z_reg + atan_q16(5'(step_reg));
            end else begin
                x_next = x_reg - ys; y_next = y_reg + xs;
                z_next = z_reg - atan_q16(5'(step_reg));
            end
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        zero_reg <= zero_next;
    end

    assign zr    = (z_reg + ANG_W'(4)) >>> 3;
    assign done  = done_reg;
    assign angle = zero_reg ? 18'sd0 : 18'(zr);
endmodule

@@ hw/rtl/waypoint_follow_wheel_speed_unit.sv @@
// Waypoint follower: computes wheel speeds toward the current waypoint.
// Append, clear and unused codes: no result; the unit stays ready for the next item.
// Pose update: result after the table reads, the serial CORDIC loop and the error and
// mix steps, or right after the table reads with no target left. Ready again as the result appears.
// A result waits in the output register; a pose update stalls only if it is still untaken.
// aresetn is synchronous: table empty, index 0, running 0, registers to reset values.
module waypoint_follow_wheel_speed_unit
    import wfws_pkg::*;
#(
    parameter int TABLE_DEPTH  = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], x_pos[25:2], y_pos[49:26], heading[65:50], speed_value[81:66]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_speed[15:0], right_speed[31:16], running[32], target_index[43:33]
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_RD1 = 4'd1, S_CHK = 4'd2, S_RD2 = 4'd3,
                           S_GO = 4'd4, S_CW = 4'd5, S_ERR = 4'd6, S_MIX = 4'd7,
                           S_OUT = 4'd8, S_DONE = 4'd9, S_LD = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next, idx_reg, idx_next;
    logic active_reg, active_next;
    logic [13:0] max_speed_reg;
    logic [15:0] tol_reg;
    logic signed [23:0] px_reg, py_reg;
    logic signed [15:0] hd_reg, sp_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic signed [17:0] err_reg, rot_reg, tra_reg;
    logic signed [15:0] left_reg, right_reg;
    logic [10:0] idx_out_reg;
    logic run_out_reg;
    logic m_valid_reg;
    logic out_free, out_load;

    wp_entry_t wr_entry, rd_entry;
    logic [WP_W-1:0] rd_word;
    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic cw_start, cw_done;
    logic signed [17:0] angle;

    logic signed [24:0] dx_c, dy_c, adx, ady;
    logic signed [17:0] err_c, err_w, rot_c, tra_c, mx, sum, dif;
    logic signed [18:0] l_full, r_full;
    logic in_tol, wr_en;

    assign s_tready = (state_reg == S_IDLE);
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            1'b0:    prdata = {18'd0, max_speed_reg};
            default: prdata = {16'd0, tol_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= MAX_SPEED_RST;
            tol_reg <= TOL_RST;
        end else if (wr_en && paddr == REG_MAX_SPEED) begin
            max_speed_reg <= pwdata[13:0];
        end else if (wr_en && paddr == REG_TOL) begin
            tol_reg <= pwdata[15:0];
        end
    end

    assign wr_entry = '{x: s_tdata[25:2], y: s_tdata[49:26], v: s_tdata[81:66]};
    assign ram_we = s_tvalid && s_tready && s_tdata[1:0] == OP_APPEND
                    && count_reg < CNTW'(TABLE_DEPTH);
    assign ram_addr = (state_reg == S_IDLE) ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign rd_entry = wp_entry_t'(rd_word);

    wfws_ram #(.WIDTH(WP_W), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(wr_entry), .rdata(rd_word)
    );

    assign cw_start = (state_reg == S_GO);
    wfws_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cw_start),
        .dx(dx_reg), .dy(dy_reg), .done(cw_done), .angle(angle)
    );

    assign dx_c = 25'(rd_entry.x) - 25'(px_reg);
    assign dy_c = 25'(rd_entry.y) - 25'(py_reg);
    assign adx = dx_c[24] ? -dx_c : dx_c;
    assign ady = dy_c[24] ? -dy_c : dy_c;
    assign in_tol = adx <= $signed({9'd0, tol_reg}) && ady < $signed({9'd0, tol_reg});

    assign err_c = angle - 18'(hd_reg);
    always_comb begin
        if (err_reg <= -PI_Q13)     err_w = err_reg + TWO_PI_Q13;
        else if (err_reg > PI_Q13)  err_w = err_reg - TWO_PI_Q13;
        else                        err_w = err_reg;
        if (err_w > ROT_LIMIT)       rot_c = ROT_LIMIT;
        else if (err_w < -ROT_LIMIT) rot_c = -ROT_LIMIT;
        else                         rot_c = err_w;
    end

    // translation limit
    assign mx = $signed({4'd0, max_speed_reg});
    assign sum = tra_reg + rot_reg;
    assign dif = tra_reg - rot_reg;
    always_comb begin
        tra_c = tra_reg;
        if ((tra_reg > 0 && rot_reg > 0) || (tra_reg < 0 && rot_reg < 0)) begin
            if (sum > mx)       tra_c = mx - rot_reg;
            else if (sum < -mx) tra_c = -mx - rot_reg;
        end else if ((tra_reg > 0 && rot_reg < 0) || (tra_reg < 0 && rot_reg > 0)) begin
            if (dif > mx)       tra_c = mx + rot_reg;
            else if (dif < -mx) tra_c = -mx + rot_reg;
        end
    end

    assign l_full = 19'(tra_reg) + 19'(rot_reg);
    assign r_full = 19'(tra_reg) - 19'(rot_reg);

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767)       sat16 = 16'sh7FFF;
        else if (v < -19'sd32768) sat16 = 16'sh8000;
        else                      sat16 = 16'(v);
    endfunction

    // output register can take a new result
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = (state_reg == S_OUT || state_reg == S_DONE) && out_free;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        active_next = active_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) begin
                case (s_tdata[1:0])
                    OP_APPEND: if (count_reg < CNTW'(TABLE_DEPTH)) begin
                        count_next = count_reg + 1'b1;
                        active_next = 1'b1;
                    end
                    OP_CLEAR: begin
                        count_next = '0; idx_next = '0; active_next = 1'b0;
                    end
                    OP_POSE: state_next = S_RD1;
                    default: ;
                endcase
            end
            S_RD1: state_next = (idx_reg < count_reg) ? S_CHK : S_RD2;
            S_CHK: begin
                if (in_tol) idx_next = idx_reg + 1'b1;
                state_next = S_RD2;
            end
            S_RD2: begin
                if (idx_reg >= count_reg) begin
                    active_next = 1'b0;
                    state_next = S_DONE;
                end else state_next = S_LD;
            end
            // table read of the final target index lands here
            S_LD: state_next = S_GO;
            S_GO: state_next = S_CW;
            S_CW: if (cw_done) state_next = S_ERR;
            S_ERR: state_next = S_MIX;
            S_MIX: state_next = S_OUT;
            S_OUT: if (out_free) state_next = S_IDLE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            active_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            active_reg <= active_next;
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            px_reg <= s_tdata[25:2];
            py_reg <= s_tdata[49:26];
            hd_reg <= s_tdata[65:50];
        end
        if (state_reg == S_LD) begin
            dx_reg <= dx_c;
            dy_reg <= dy_c;
            sp_reg <= rd_entry.v;
        end
        if (cw_done) err_reg <= err_c;
        if (state_reg == S_ERR) begin
            rot_reg <= rot_c;
            tra_reg <= 18'(sp_reg);
        end
        if (state_reg == S_MIX) tra_reg <= tra_c;
        if (out_load) begin
            idx_out_reg <= 11'(idx_reg);
            run_out_reg <= active_reg;
            if (state_reg == S_OUT) begin
                left_reg <= sat16(l_full);
                right_reg <= sat16(r_full);
            end else begin
                left_reg <= '0;
                right_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {4'd0, idx_out_reg, run_out_reg, right_reg, left_reg};
endmodule

@@ hw/rtl/wfws_checker.sv @@
// Port-level checker for the waypoint follower, bound to the top level.
module wfws_prop_checker
    import wfws_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [87:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_pose: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[1:0] == OP_POSE |=> !s_tready)
        else $error("ready during pose update");

    a_stopped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero speed while stopped");
endmodule

bind waypoint_follow_wheel_speed_unit wfws_prop_checker u_wfws_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ verif/wfws_checker.sv @@
// Checker for the waypoint follower: predicts wheel speed results and compares them.
module wfws_checker
    import wfws_pkg::*;
#(
    parameter logic [2:0] ADDR_MAX_SPEED = 3'd0,
    parameter logic [2:0] ADDR_TOL       = 3'd4,
    parameter int         DEPTH          = 1024,
    parameter int         STEPS          = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               running;
        logic [10:0]        index;
    } speeds_t;

    speeds_t    speeds_q[$];
    logic signed [23:0] tab_x[DEPTH];
    logic signed [23:0] tab_y[DEPTH];
    logic signed [15:0] tab_v[DEPTH];
    int         wp_cnt, wp_idx;
    logic       active;
    logic [13:0] lim_speed;
    logic [15:0] reach;
    longint     arctan_q16[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2, 1};

    initial begin
        errors = 0;
        pending = 0;
    end

    // atan2(dy, dx) in Q3.13 by CORDIC vectoring at 16 fractional bits
    function automatic longint bearing_q13(longint dx, longint dy);
        longint x, y, z, t;
        if (dx == 0 && dy == 0) return 0;
        x = dx; y = dy; z = 0;
        if (dx < 0) begin
            if (dy >= 0) begin
                x = dy; y = -dx; z = 102944;
            end else begin
                x = -dy; y = dx; z = -102944;
            end
        end
        for (int i = 0; i < STEPS && i < 17; i++) begin
            t = x;
            if (y >= 0) begin
                x += y >>> i; y -= t >>> i; z += arctan_q16[i];
            end else begin
                x -= y >>> i; y += t >>> i; z -= arctan_q16[i];
            end
        end
        return (z + 4) >>> 3;
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic predict(input logic [87:0] d);
        logic [1:0] op;
        longint px, py, hd, sp, dx, dy, err, rot, tra, mx;
        speeds_t e;
        op = d[1:0];
        px = longint'($signed(d[25:2]));
        py = longint'($signed(d[49:26]));
        hd = longint'($signed(d[65:50]));
        sp = longint'($signed(d[81:66]));
        if (op == OP_APPEND) begin
            if (wp_cnt < DEPTH) begin
                tab_x[wp_cnt] = 24'(px); tab_y[wp_cnt] = 24'(py); tab_v[wp_cnt] = 16'(sp);
                wp_cnt++;
                active = 1'b1;
            end
        end else if (op == OP_CLEAR) begin
            wp_cnt = 0; wp_idx = 0; active = 1'b0;
        end else if (op == OP_POSE) begin
            e.left = '0; e.right = '0;
            if (wp_idx < wp_cnt) begin
                dx = longint'(tab_x[wp_idx]) - px;
                dy = longint'(tab_y[wp_idx]) - py;
                if ((dx < 0 ? -dx : dx) <= longint'(reach)
                    && (dy < 0 ? -dy : dy) < longint'(reach)) wp_idx++;
            end
            if (wp_idx >= wp_cnt) begin
                active = 1'b0;
            end else begin
                dx = longint'(tab_x[wp_idx]) - px;
                dy = longint'(tab_y[wp_idx]) - py;
                err = bearing_q13(dx, dy) - hd;
                mx = longint'(lim_speed);
                if (err <= -25736) err += 51472;
                else if (err > 25736) err -= 51472;
                rot = err > 2048 ? 2048 : (err < -2048 ? -2048 : err);
                tra = longint'(tab_v[wp_idx]);
                if ((tra > 0 && rot > 0) || (tra < 0 && rot < 0)) begin
                    if (tra + rot > mx) tra = mx - rot;
                    else if (tra + rot < -mx) tra = -mx - rot;
                end else if ((tra > 0 && rot < 0) || (tra < 0 && rot > 0)) begin
                    if (tra - rot > mx) tra = mx + rot;
                    else if (tra - rot < -mx) tra = -mx + rot;
                end
                e.left = 16'(sat16(tra + rot));
                e.right = 16'(sat16(tra - rot));
            end
            e.running = active;
            e.index = 11'(wp_idx);
            speeds_q = {speeds_q, e};
        end
    endtask

    task automatic compare(input logic [47:0] d);
        speeds_t e, a;
        a = {d[15:0], d[31:16], d[32], d[43:33]};
        if (speeds_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h", $time, a);
        end else begin
            e = speeds_q.pop_front();
            if (a.left !== e.left) begin
                errors++;
                $display("%0t: left_speed exp %0d got %0d", $time, e.left, a.left);
            end
            if (a.right !== e.right) begin
                errors++;
                $display("%0t: right_speed exp %0d got %0d", $time, e.right, a.right);
            end
            if (a.running !== e.running) begin
                errors++;
                $display("%0t: running exp %0d got %0d", $time, e.running, a.running);
            end
            if (a.index !== e.index) begin
                errors++;
                $display("%0t: target_index exp %0d got %0d", $time, e.index, a.index);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            wp_cnt = 0; wp_idx = 0; active = 1'b0;
            lim_speed = MAX_SPEED_RST;
            reach = TOL_RST;
            speeds_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_MAX_SPEED) lim_speed = pwdata[13:0];
                else if (paddr == ADDR_TOL) reach = pwdata[15:0];
            end
            // a result never belongs to the item taken on the same edge
            if (m_tvalid && m_tready) compare(m_tdata);
            if (s_tvalid && s_tready) predict(s_tdata);
        end
        pending = speeds_q.size();
    end

endmodule

@@ verif/tb.sv @@
// Stimulus and verdict for the waypoint follower wheel speed unit.
module tb;
    import wfws_pkg::*;

    localparam logic [2:0] ADDR_MAX_SPEED = 3'd0;
    localparam logic [2:0] ADDR_TOL       = 3'd4;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int DEPTH = 1024;
    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    int          cycles = 0;
    logic        no_gaps = 1'b0;

    // mirror of the table, used only to aim poses at the live target
    logic signed [23:0] aim_x[DEPTH];
    logic signed [23:0] aim_y[DEPTH];
    int aim_cnt = 0, aim_idx = 0;
    int reach = 1311;

    waypoint_follow_wheel_speed_unit uut (.*);

    wfws_checker #(.ADDR_MAX_SPEED(ADDR_MAX_SPEED), .ADDR_TOL(ADDR_TOL)) u_checker (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side stalls per item
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            g = no_gaps ? 0 : $urandom_range(0, 9);
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send(input logic [1:0] op, input logic signed [23:0] x,
                        input logic signed [23:0] y, input logic signed [15:0] hd,
                        input logic signed [15:0] sp);
        int g;
        longint dx, dy;
        g = no_gaps ? 0 : $urandom_range(0, 9);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, sp, hd, y, x, op};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_APPEND && aim_cnt < DEPTH) begin
            aim_x[aim_cnt] = x; aim_y[aim_cnt] = y; aim_cnt++;
        end else if (op == OP_CLEAR) begin
            aim_cnt = 0; aim_idx = 0;
        end else if (op == OP_POSE && aim_idx < aim_cnt) begin
            dx = longint'(aim_x[aim_idx]) - x;
            dy = longint'(aim_y[aim_idx]) - y;
            if ((dx < 0 ? -dx : dx) <= reach && (dy < 0 ? -dy : dy) < reach) aim_idx++;
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_regs(input int spd, input int tol);
        drain();
        apb_write(ADDR_MAX_SPEED, spd);
        apb_write(ADDR_TOL, tol);
        reach = tol;
    endtask

    function automatic logic [23:0] rnd24();
        return 24'($urandom);
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] rand_heading();
        if ($urandom_range(0, 7) == 0) return rnd16();
        return 16'($signed($urandom_range(0, 51472)) - 25736);
    endfunction

    function automatic logic signed [15:0] rand_speed();
        if ($urandom_range(0, 7) == 0) return rnd16();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic signed [23:0] rand_coord();
        if ($urandom_range(0, 5) == 0) return rnd24();
        return 24'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    endfunction

    // well-formed runs: appends and poses aimed near the live target, with noise
    task automatic random_phase(input int n);
        int r, ox, oy;
        logic signed [23:0] x, y;
        send(OP_CLEAR, rnd24(), rnd24(), rnd16(), rnd16());
        for (int k = 0; k < 3; k++)
            send(OP_APPEND, rand_coord(), rand_coord(), 16'sd0, rand_speed());
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send(OP_CLEAR, rnd24(), rnd24(), rnd16(), rnd16());
            end else if (r < 6) begin
                send(OP_UNUSED, rnd24(), rnd24(), rnd16(), rnd16());
            end else if (r < 26 || aim_cnt == 0) begin
                send(OP_APPEND, rand_coord(), rand_coord(), rnd16(), rand_speed());
            end else if (aim_idx < aim_cnt && r < 85) begin
                ox = $signed($urandom_range(0, 4 * reach + 2)) - 2 * reach - 1;
                oy = $signed($urandom_range(0, 4 * reach + 2)) - 2 * reach - 1;
                if ($urandom_range(0, 3) == 0) begin
                    ox = $signed($urandom_range(0, 400000)) - 200000;
                    oy = $signed($urandom_range(0, 400000)) - 200000;
                end
                x = 24'(aim_x[aim_idx] - ox);
                y = 24'(aim_y[aim_idx] - oy);
                send(OP_POSE, x, y, rand_heading(), rnd16());
            end else begin
                send(OP_POSE, rnd24(), rnd24(), rand_heading(), rnd16());
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: empty table, unused code, heading wrap, extremes
        send(OP_POSE, 24'sd0, 24'sd0, 16'sd0, 16'sd0);
        send(OP_UNUSED, '1, '1, '1, '1);
        send(OP_APPEND, 24'sd100000, -24'sd50000, 16'sd0, 16'sd16384);
        send(OP_POSE, -24'sd300000, 24'sd70000, 16'sd25736, 16'sd0);
        send(OP_POSE, 24'sd400000, 24'sd70000, -16'sd25736, 16'sd0);
        send(OP_POSE, 24'sd0, 24'sd0, 16'sh7fff, 16'sd0);
        send(OP_POSE, 24'sd0, -24'sd900000, 16'sh8000, 16'sd0);
        send(OP_APPEND, 24'sh7fffff, 24'sh800000, 16'sd0, -16'sd16384);
        send(OP_POSE, 24'sd100000 - 24'sd1311, -24'sd50000, 16'sd0, 16'sd0);
        send(OP_POSE, 24'sh800000, 24'sh7fffff, 16'sd100, 16'sd0);
        send(OP_APPEND, 24'sh800000, 24'sh7fffff, 16'sd0, 16'sh7fff);
        send(OP_APPEND, 24'sd0, 24'sd0, 16'sd0, 16'sh8000);
        send(OP_POSE, 24'sh7fffff, 24'sh800000, 16'sd0, 16'sd0);
        send(OP_POSE, 24'sh7fffff, 24'sh800000 + 24'sd1311, 16'sd0, 16'sd0);
        send(OP_POSE, 24'sd5, 24'sd0, 16'sd0, 16'sd0);
        send(OP_CLEAR, '0, '0, '0, '0);
        send(OP_POSE, 24'sd0, 24'sd0, 16'sd0, 16'sd0);

        // zero limits: target exactly at the pose never advances, bearing taken as 0
        set_regs(0, 0);
        send(OP_APPEND, 24'sd0, 24'sd0, 16'sd0, 16'sd3000);
        send(OP_POSE, 24'sd0, 24'sd0, 16'sd700, 16'sd0);
        send(OP_POSE, 24'sd0, 24'sd0, -16'sd700, 16'sd0);
        random_phase(90);

        set_regs(16383, 65535);
        send(OP_CLEAR, '0, '0, '0, '0);
        send(OP_APPEND, 24'sd0, 24'sd500000, 16'sd0, 16'sh7fff);
        send(OP_POSE, 24'sd0, 24'sd0, 16'sd0, 16'sd0);
        send(OP_POSE, 24'sd0, 24'sd0, 16'sd10000, 16'sd0);
        random_phase(90);

        set_regs($urandom_range(0, 16383), $urandom_range(0, 65535));
        random_phase(90);

        set_regs($urandom_range(0, 4096), $urandom_range(500, 20000));
        random_phase(90);

        // short table back to back, then walk the index past the end
        set_regs(2048, 1000);
        no_gaps = 1'b1;
        send(OP_CLEAR, '0, '0, '0, '0);
        for (int k = 0; k < 20; k++) send(OP_APPEND, 24'sd0, 24'sd0, 16'sd0, rand_speed());
        for (int k = 0; k <= 20; k++) send(OP_POSE, 24'sd0, 24'sd0, rand_heading(), 16'sd0);
        no_gaps = 1'b0;

        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
